// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the note register writer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// General implication property, checked on every rising clock edge.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition that must never be true.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)
`endif

`endif

// ----- hdl/onrw_pkg.sv -----
// ----------------------------------------------------------------------------
// onrw_pkg
// Types, constants, tables and helper functions of the note register writer.
// ----------------------------------------------------------------------------
package onrw_pkg;

  localparam int NOTE_TABLE_SIZE  = 96;
  localparam int LOGICAL_CHANNELS = 4;
  localparam int QUEUE_DEPTH      = 2;

  // Only the first 96 entries of the period table exist.
  localparam int NOTE_SCAN = (NOTE_TABLE_SIZE < 96) ? NOTE_TABLE_SIZE : 96;
  localparam int NOTE_W    = $clog2(NOTE_SCAN);
  localparam int COUNT_W   = $clog2(NOTE_SCAN + 1);

  // Request and driver codes.
  localparam logic MODE_SET    = 1'b0;
  localparam logic MODE_STOP   = 1'b1;
  localparam logic VARIANT_INS = 1'b0;
  localparam logic VARIANT_ADL = 1'b1;

  // Chip register addresses and bits.
  localparam logic [7:0] ADDR_FNUM_LO = 8'hA0;
  localparam logic [7:0] ADDR_BLOCK   = 8'hB0;
  localparam logic [7:0] ADDR_RHYTHM  = 8'hBD;
  localparam logic [7:0] KEY_ON       = 8'h20;
  localparam logic [7:0] RHYTHM_RESET = 8'h20;
  localparam logic [3:0] VOICE_BASS   = 4'd6;
  localparam logic [3:0] VOICE_TOP    = 4'd10;
  localparam logic [3:0] VOICE_NINE   = 4'd9;
  localparam logic [3:0] VOICE_SEVEN  = 4'd7;
  localparam logic [3:0] VOICE_EIGHT  = 4'd8;

  localparam logic [11:0] PERIOD_TAB [96] = '{
    12'hEEE, 12'hE17, 12'hD4D, 12'hC8C, 12'hBD9, 12'hB2F, 12'hA8E, 12'h9F7,
    12'h967, 12'h8E0, 12'h861, 12'h7E8, 12'h777, 12'h70B, 12'h6A6, 12'h647,
    12'h5EC, 12'h597, 12'h547, 12'h4FB, 12'h4B3, 12'h470, 12'h430, 12'h3F4,
    12'h3BB, 12'h385, 12'h353, 12'h323, 12'h2F6, 12'h2CB, 12'h2A3, 12'h27D,
    12'h259, 12'h238, 12'h218, 12'h1FA, 12'h1DD, 12'h1C2, 12'h1A9, 12'h191,
    12'h17B, 12'h165, 12'h151, 12'h13E, 12'h12C, 12'h11C, 12'h10C, 12'h0FD,
    12'h0EE, 12'h0E1, 12'h0D4, 12'h0C8, 12'h0BD, 12'h0B2, 12'h0A8, 12'h09F,
    12'h096, 12'h08E, 12'h086, 12'h07E, 12'h077, 12'h070, 12'h06A, 12'h064,
    12'h05E, 12'h059, 12'h054, 12'h04F, 12'h04B, 12'h047, 12'h043, 12'h03F,
    12'h03B, 12'h038, 12'h035, 12'h032, 12'h02F, 12'h02C, 12'h02A, 12'h027,
    12'h025, 12'h023, 12'h021, 12'h01F, 12'h01D, 12'h01C, 12'h01A, 12'h019,
    12'h017, 12'h016, 12'h015, 12'h013, 12'h012, 12'h011, 12'h010, 12'h00F
  };

  localparam logic [9:0] FNUM_TAB [12] = '{
    10'h157, 10'h16C, 10'h181, 10'h198, 10'h1B1, 10'h1CB,
    10'h1E6, 10'h203, 10'h222, 10'h243, 10'h266, 10'h28A
  };

  typedef struct packed {
    logic        mode;
    logic [1:0]  channel;
    logic [14:0] period;
    logic        rhythm_mode;
    logic [3:0]  rhythm_voice;
    logic [7:0]  fixed_note;
  } req_t;

  typedef struct packed {
    logic [7:0] reg_addr;
    logic [7:0] reg_data;
    logic       last;
  } wr_t;

  // One classified event: up to two plain writes, then an optional rhythm write.
  typedef struct packed {
    logic [1:0] nw;
    logic [7:0] a0;
    logic [7:0] d0;
    logic [7:0] a1;
    logic [7:0] d1;
    logic       bd;
    logic       bd_set;
    logic [7:0] mask;
  } cmd_t;

  typedef struct packed {
    logic [4:0] q;
    logic [3:0] r;
  } div12_t;

  // Division by twelve through a reciprocal; exact for all 8-bit values.
  function automatic div12_t div12(input logic [7:0] v);
    logic [15:0] prod;
    div12_t      d;
    prod = 16'(v) * 16'd171;
    d.q  = prod[15:11];
    d.r  = 4'(v - 8'(d.q) * 8'd12);
    return d;
  endfunction

  // Percussion bit of a rhythm voice; voices above ten or below three have none.
  function automatic logic [7:0] perc_mask(input logic [3:0] voice);
    logic [10:0] oh;
    oh = '0;
    if (voice <= VOICE_TOP) begin
      oh = 11'(1) << (VOICE_TOP - voice);
    end
    return oh[7:0];
  endfunction

endpackage

// ----- hdl/onrw_front.sv -----
// ----------------------------------------------------------------------------
// onrw_front
// Accepts note events, looks up the note and classifies each event into a
// command of register writes for the back end.
// ----------------------------------------------------------------------------
module onrw_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                variant,
  input  logic                req_valid,
  output logic                req_stall,
  input  onrw_pkg::req_t      req,
  output logic                push,
  output onrw_pkg::cmd_t      cmd,
  input  logic                q_full
);

  logic                             s1_valid;
  onrw_pkg::req_t                   s1;
  logic [onrw_pkg::NOTE_SCAN-1:0]   s1_gt;
  onrw_pkg::div12_t                 s1_fd;

  logic [onrw_pkg::NOTE_SCAN-1:0]   gt;
  logic                             accept;
  logic                             drop;
  logic                             s1_move;

  logic [onrw_pkg::COUNT_W-1:0]     cnt;
  logic [onrw_pkg::COUNT_W-1:0]     probe;
  logic [onrw_pkg::NOTE_W-1:0]      n0;
  onrw_pkg::div12_t                 nd;
  logic [4:0]                       oct;
  logic [3:0]                       semi;
  logic [9:0]                       fnum;
  logic [7:0]                       blk;
  logic [3:0]                       voice;
  logic                             melodic;
  logic                             is_bass;
  logic [7:0]                       mask;

  // Period compares against every table entry; the table descends, so the
  // result is a thermometer code.
  always_comb begin
    for (int i = 0; i < onrw_pkg::NOTE_SCAN; i++) begin
      gt[i] = {3'b000, onrw_pkg::PERIOD_TAB[i]} > req.period;
    end
  end

  assign drop      = int'(s1.channel) >= onrw_pkg::LOGICAL_CHANNELS;
  assign s1_move   = s1_valid && (drop || !q_full);
  assign req_stall = s1_valid && !s1_move;
  assign accept    = req_valid && !req_stall;
  assign push      = s1_valid && !drop && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1    <= req;
      s1_gt <= gt;
      s1_fd <= onrw_pkg::div12(req.fixed_note);
    end
  end

  // Count of leading ones by binary search over the thermometer code.
  always_comb begin
    cnt   = '0;
    probe = '0;
    for (int j = onrw_pkg::COUNT_W - 1; j >= 0; j--) begin
      probe = cnt | onrw_pkg::COUNT_W'((1 << j) - 1);
      if (int'(probe) < onrw_pkg::NOTE_SCAN) begin
        if (s1_gt[probe]) begin
          cnt = cnt | onrw_pkg::COUNT_W'(1 << j);
        end
      end
    end
    if (int'(cnt) >= onrw_pkg::NOTE_SCAN) begin
      n0 = onrw_pkg::NOTE_W'(onrw_pkg::NOTE_SCAN - 1);
    end else begin
      n0 = cnt[onrw_pkg::NOTE_W-1:0];
    end
  end

  always_comb begin
    nd      = onrw_pkg::div12(8'(n0));
    melodic = !s1.rhythm_mode;
    is_bass = s1.rhythm_voice == onrw_pkg::VOICE_BASS;
    mask    = onrw_pkg::perc_mask(s1.rhythm_voice);

    oct   = nd.q;
    semi  = nd.r;
    voice = {2'b00, s1.channel};
    if (variant == onrw_pkg::VARIANT_INS) begin
      if (!melodic) begin
        oct   = '0;
        voice = onrw_pkg::VOICE_BASS;
      end
    end else begin
      // Variant two uses a set fixed note, else doubles the octave step.
      if (s1.fixed_note != 8'd0) begin
        oct  = s1_fd.q;
        semi = s1_fd.r;
      end else begin
        oct = 5'(nd.q << 1);
      end
      if (!melodic) begin
        priority if (s1.rhythm_voice == onrw_pkg::VOICE_NINE) begin
          voice = onrw_pkg::VOICE_EIGHT;
        end else if (s1.rhythm_voice == onrw_pkg::VOICE_TOP) begin
          voice = onrw_pkg::VOICE_SEVEN;
        end else begin
          voice = s1.rhythm_voice;
        end
      end
    end

    fnum = onrw_pkg::FNUM_TAB[semi];
    blk  = {1'b0, oct, 2'b00} | {6'b0, fnum[9:8]};
    if (melodic) begin
      blk = blk | onrw_pkg::KEY_ON;
    end

    cmd.a0     = onrw_pkg::ADDR_FNUM_LO | {4'h0, voice};
    cmd.d0     = fnum[7:0];
    cmd.a1     = onrw_pkg::ADDR_BLOCK | {4'h0, voice};
    cmd.d1     = blk;
    cmd.nw     = 2'd2;
    cmd.bd     = !melodic;
    cmd.bd_set = 1'b1;
    cmd.mask   = mask;

    if (s1.mode == onrw_pkg::MODE_STOP) begin
      cmd.bd_set = 1'b0;
      cmd.d0     = 8'h00;
      if (melodic) begin
        cmd.nw = 2'd1;
        cmd.a0 = onrw_pkg::ADDR_BLOCK | {6'h00, s1.channel};
      end else begin
        cmd.nw = is_bass ? 2'd1 : 2'd0;
        cmd.a0 = onrw_pkg::ADDR_BLOCK | {4'h0, onrw_pkg::VOICE_BASS};
      end
    end else if (variant == onrw_pkg::VARIANT_INS && !melodic && !is_bass) begin
      cmd.nw = 2'd0;
    end
  end

endmodule

// ----- hdl/onrw_queue.sv -----
// ----------------------------------------------------------------------------
// onrw_queue
// Short command queue between the classifying front and the write sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module onrw_queue #(
  parameter int DEPTH = onrw_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  onrw_pkg::cmd_t  push_cmd,
  output logic            full,
  input  logic            pop,
  output onrw_pkg::cmd_t  head,
  output logic            empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  onrw_pkg::cmd_t mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full  = count == CW'(DEPTH);
  assign empty = count == '0;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  `ASSERT_NEVER(a_push_full, clk, rst, push && full, "queue written while full")
  `ASSERT_NEVER(a_pop_empty, clk, rst, pop && empty, "queue read while empty")
  `ASSERT_CLK(a_count_up, clk, rst, (push && !pop) |=> (count == $past(count) + CW'(1)), "queue count did not grow")

endmodule

// ----- hdl/onrw_back.sv -----
// ----------------------------------------------------------------------------
// onrw_back
// Sequences the register writes of each command, keeps the rhythm register
// and holds the output write register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module onrw_back (
  input  logic            clk,
  input  logic            rst,
  input  onrw_pkg::cmd_t  head,
  input  logic            empty,
  output logic            pop,
  output logic            wr_valid,
  input  logic            wr_stall,
  output onrw_pkg::wr_t   wr
);

  logic [1:0] idx;
  logic [7:0] rr;
  logic       out_is_bd;

  logic       load;
  logic [1:0] total;
  logic       ld_last;
  logic       ld_bd;
  logic [7:0] rr_next;

  assign load    = !empty && (!wr_valid || !wr_stall);
  assign total   = head.nw + {1'b0, head.bd};
  assign ld_last = idx == (total - 2'd1);
  assign ld_bd   = head.bd && (idx == head.nw);
  assign rr_next = head.bd_set ? (rr | head.mask) : (rr & ~head.mask);
  assign pop     = load && ld_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_valid <= 1'b0;
      idx      <= '0;
      rr       <= onrw_pkg::RHYTHM_RESET;
    end else begin
      if (load) begin
        wr_valid <= 1'b1;
        idx      <= ld_last ? 2'd0 : idx + 2'd1;
        if (ld_bd) begin
          rr <= rr_next;
        end
      end else if (!wr_stall) begin
        wr_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_is_bd <= ld_bd;
      wr.last   <= ld_last;
      if (ld_bd) begin
        wr.reg_addr <= onrw_pkg::ADDR_RHYTHM;
        wr.reg_data <= rr_next;
      end else if (idx == 2'd0) begin
        wr.reg_addr <= head.a0;
        wr.reg_data <= head.d0;
      end else begin
        wr.reg_addr <= head.a1;
        wr.reg_data <= head.d1;
      end
    end
  end

  `ASSERT_NEVER(a_idx_range, clk, rst, !empty && (idx >= total), "write index beyond command")
  `ASSERT_CLK(a_bd_data, clk, rst, (wr_valid && out_is_bd) |-> (wr.reg_data == rr), "rhythm write does not match kept register")
  `ASSERT_CLK(a_last_wraps, clk, rst, (load && ld_last) |=> (idx == 2'd0), "write index not cleared after last write")

endmodule

// ----- hdl/opl_note_register_writer.sv -----
// ----------------------------------------------------------------------------
// opl_note_register_writer
// Turns note events into FM-chip register writes (address, data, last).
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid / req_stall  onrw_pkg::req_t
//   wr       out        wr_valid / wr_stall    onrw_pkg::wr_t
//   cfg      in         cfg_we                 cfg_data (driver variant)
//
// An accepted event is registered in the front, then pushed into the command
// queue, and its first write is registered onto wr; the front takes a new
// event every cycle while the queue has room.
// The back end issues one register write per cycle while wr does not stall;
// an event carries one to three writes, whose count sets the sustained rate.
// Reset is synchronous; there is no clearing pass after it.
// The output register parts both sides: a stall on wr holds the write and
// backs up the queue, then the front.
// ----------------------------------------------------------------------------
module opl_note_register_writer #(
  parameter int QUEUE_DEPTH = onrw_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic            cfg_data,
  input  logic            req_valid,
  output logic            req_stall,
  input  onrw_pkg::req_t  req,
  output logic            wr_valid,
  input  logic            wr_stall,
  output onrw_pkg::wr_t   wr
);

  logic           variant;
  logic           push;
  onrw_pkg::cmd_t push_cmd;
  logic           q_full;
  logic           pop;
  onrw_pkg::cmd_t head;
  logic           q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      variant <= onrw_pkg::VARIANT_INS;
    end else if (cfg_we) begin
      variant <= cfg_data;
    end
  end

  onrw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .variant   (variant),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .push      (push),
    .cmd       (push_cmd),
    .q_full    (q_full)
  );

  onrw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty)
  );

  onrw_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (q_empty),
    .pop      (pop),
    .wr_valid (wr_valid),
    .wr_stall (wr_stall),
    .wr       (wr)
  );

endmodule

// ----- sim/opl_note_register_writer_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// opl_note_register_writer_tb
// Feeds note events to the register writer under both driver variants and
// checks every chip register write against a predictor that tracks the
// rhythm register, with random request idle cycles and write back-pressure.
// ----------------------------------------------------------------------------
module opl_note_register_writer_tb;
  import onrw_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int IDLE_PERCENT = 28;
  localparam int DRAIN_CYCLES = 10;
  localparam int NO_BIT       = 0;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_data = 1'b0;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic wr_valid;
  logic wr_stall = 1'b0;
  wr_t  wr;

  req_t note_events[$];
  wr_t  expected_writes[$];

  logic variant_sel = VARIANT_INS;
  logic [7:0] rhythm_shadow = RHYTHM_RESET;
  logic steady = 1'b0;
  int   err_count = 0;
  int   events_sent = 0;
  int   writes_checked = 0;
  int   rhythm_events = 0;
  int   cycle_count = 0;

  opl_note_register_writer u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .wr_valid (wr_valid),
    .wr_stall (wr_stall),
    .wr       (wr)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic req_t make_event(input logic mode, input int ch, input int period,
                                      input logic rm, input int rv, input int fixed);
    req_t e;
    e.mode = mode;
    e.channel = 2'(ch);
    e.period = 15'(period);
    e.rhythm_mode = rm;
    e.rhythm_voice = 4'(rv);
    e.fixed_note = 8'(fixed);
    return e;
  endfunction

  // Index of the first period entry not above the given period.
  function automatic int note_index(input logic [14:0] period);
    for (int i = 0; i < NOTE_SCAN; i++) begin
      if (15'(PERIOD_TAB[i]) <= period) begin
        return i;
      end
    end
    return NOTE_SCAN - 1;
  endfunction

  function automatic logic [7:0] percussion_bit(input logic [3:0] voice);
    int b;
    if (voice > VOICE_TOP) begin
      return 8'(NO_BIT);
    end
    b = 1 << (10 - int'(voice));
    return 8'(b);
  endfunction

  task automatic push_write(input logic [7:0] addr, input logic [7:0] data);
    wr_t w;
    w.reg_addr = addr;
    w.reg_data = data;
    w.last = 1'b0;
    expected_writes.push_back(w);
  endtask

  task automatic push_note(input int voice, input int n, input logic melodic);
    logic [9:0] fnum;
    logic [7:0] blk;
    fnum = FNUM_TAB[n % 12];
    blk = 8'(((n / 12) << 2) | int'(fnum[9:8]));
    if (melodic) begin
      blk = blk | KEY_ON;
    end
    push_write(ADDR_FNUM_LO | 8'(voice), fnum[7:0]);
    push_write(ADDR_BLOCK | 8'(voice), blk);
  endtask

  // Expected register writes of one accepted note event.
  task automatic predict_writes(input req_t e);
    int prior_count;
    int n;
    int voice;
    prior_count = expected_writes.size();
    voice = int'(e.channel);
    if (e.rhythm_mode) begin
      rhythm_events++;
    end
    if (e.mode == MODE_STOP) begin
      if (!e.rhythm_mode) begin
        push_write(ADDR_BLOCK | 8'(e.channel), 8'h00);
      end else begin
        if (e.rhythm_voice == VOICE_BASS) begin
          push_write(ADDR_BLOCK | 8'(VOICE_BASS), 8'h00);
        end
        rhythm_shadow = rhythm_shadow & ~percussion_bit(e.rhythm_voice);
        push_write(ADDR_RHYTHM, rhythm_shadow);
      end
    end else if (variant_sel == VARIANT_INS) begin
      if (!e.rhythm_mode || e.rhythm_voice == VOICE_BASS) begin
        n = note_index(e.period);
        if (e.rhythm_mode) begin
          // The bass drum always plays in block zero on voice six.
          voice = int'(VOICE_BASS);
          n = n % 12;
        end
        push_note(voice, n, !e.rhythm_mode);
      end
      if (e.rhythm_mode) begin
        rhythm_shadow = rhythm_shadow | percussion_bit(e.rhythm_voice);
        push_write(ADDR_RHYTHM, rhythm_shadow);
      end
    end else begin
      n = note_index(e.period);
      if (e.rhythm_mode) begin
        voice = int'(e.rhythm_voice);
        if (e.rhythm_voice == VOICE_NINE) begin
          voice = int'(VOICE_EIGHT);
        end else if (e.rhythm_voice == VOICE_TOP) begin
          voice = int'(VOICE_SEVEN);
        end
      end
      n = n + (n / 12) * 12;
      if (e.fixed_note != 8'h00) begin
        n = int'(e.fixed_note);
      end
      push_note(voice, n, !e.rhythm_mode);
      if (e.rhythm_mode) begin
        rhythm_shadow = rhythm_shadow | percussion_bit(e.rhythm_voice);
        push_write(ADDR_RHYTHM, rhythm_shadow);
      end
    end
    if (expected_writes.size() > prior_count) begin
      expected_writes[expected_writes.size() - 1].last = 1'b1;
    end
  endtask

  function automatic req_t random_event(input logic mode);
    req_t e;
    int pick;
    e.mode = mode;
    e.channel = 2'($urandom_range(3));
    pick = $urandom_range(2);
    if (pick == 0) begin
      e.period = 15'($urandom_range(32767, 1));
    end else if (pick == 1) begin
      e.period = 15'($urandom_range(12'hEEE, 12'h00F));
    end else begin
      e.period = 15'($urandom_range(40));
    end
    e.rhythm_mode = ($urandom_range(99) < 40);
    if ($urandom_range(99) < 75) begin
      e.rhythm_voice = 4'($urandom_range(10, 6));
    end else begin
      e.rhythm_voice = 4'($urandom_range(15));
    end
    e.fixed_note = ($urandom_range(1) == 0) ? 8'h00 : 8'($urandom_range(255));
    return e;
  endfunction

  // Often a note followed by its own stop, otherwise a lone event.
  task automatic queue_random(input int count);
    req_t e;
    int made;
    made = 0;
    while (made < count) begin
      if ($urandom_range(99) < 60) begin
        e = random_event(MODE_SET);
        note_events.push_back(e);
        if ($urandom_range(99) < 70) begin
          e.mode = MODE_STOP;
          e.period = 15'($urandom_range(32767));
          e.fixed_note = 8'($urandom_range(255));
          note_events.push_back(e);
          made++;
        end
      end else begin
        note_events.push_back(
          random_event(($urandom_range(99) < 30) ? MODE_STOP : MODE_SET));
      end
      made++;
    end
  endtask

  task automatic wait_idle();
    while (note_events.size() != 0 || req_valid || expected_writes.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_variant(input logic v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    variant_sel = v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Event source.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        predict_writes(req);
        events_sent++;
      end
      if (!req_valid || !req_stall) begin
        if (note_events.size() != 0 && (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
          req <= note_events.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Write checker.
  always @(posedge clk) begin
    wr_t want;
    if (rst) begin
      wr_stall <= 1'b0;
    end else begin
      wr_stall <= steady ? 1'b0 : ($urandom_range(99) < IDLE_PERCENT);
      if (wr_valid && !wr_stall) begin
        if (expected_writes.size() == 0) begin
          report_error($sformatf("unexpected write addr=%02h data=%02h last=%0b",
                                 wr.reg_addr, wr.reg_data, wr.last));
        end else begin
          want = expected_writes.pop_front();
          writes_checked++;
          if (wr.reg_addr !== want.reg_addr) begin
            report_error($sformatf("reg_addr %02h, expected %02h", wr.reg_addr, want.reg_addr));
          end
          if (wr.reg_data !== want.reg_data) begin
            report_error($sformatf("reg_data %02h, expected %02h (addr %02h)",
                                   wr.reg_data, want.reg_data, want.reg_addr));
          end
          if (wr.last !== want.last) begin
            report_error($sformatf("last %0b, expected %0b (addr %02h)",
                                   wr.last, want.last, want.reg_addr));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    write_variant(VARIANT_INS);

    // Table extremes, exact and in-between periods, every rhythm voice class.
    note_events.push_back(make_event(MODE_SET, 0, 32767, 1'b0, 0, 0));
    note_events.push_back(make_event(MODE_SET, 1, 12'h00F, 1'b0, 0, 0));
    note_events.push_back(make_event(MODE_SET, 2, 0, 1'b0, 0, 0));
    note_events.push_back(make_event(MODE_SET, 3, 1, 1'b0, 15, 255));
    note_events.push_back(make_event(MODE_SET, 0, 12'hEEE, 1'b0, 0, 0));
    note_events.push_back(make_event(MODE_SET, 1, 12'hEED, 1'b0, 0, 0));
    note_events.push_back(make_event(MODE_SET, 2, 12'h100, 1'b1, 6, 0));
    note_events.push_back(make_event(MODE_SET, 3, 12'h200, 1'b1, 10, 0));
    note_events.push_back(make_event(MODE_SET, 0, 12'h200, 1'b1, 7, 0));
    note_events.push_back(make_event(MODE_SET, 1, 12'h200, 1'b1, 2, 0));
    note_events.push_back(make_event(MODE_SET, 2, 12'h200, 1'b1, 11, 0));
    note_events.push_back(make_event(MODE_STOP, 1, 0, 1'b0, 0, 0));
    note_events.push_back(make_event(MODE_STOP, 2, 0, 1'b1, 6, 0));
    note_events.push_back(make_event(MODE_STOP, 3, 0, 1'b1, 10, 0));
    wait_idle();

    write_variant(VARIANT_ADL);
    note_events.push_back(make_event(MODE_SET, 0, 32767, 1'b0, 0, 0));
    note_events.push_back(make_event(MODE_SET, 1, 12'h00F, 1'b0, 0, 0));
    note_events.push_back(make_event(MODE_SET, 2, 12'h300, 1'b0, 0, 255));
    note_events.push_back(make_event(MODE_SET, 3, 12'h300, 1'b0, 0, 1));
    note_events.push_back(make_event(MODE_SET, 0, 12'h150, 1'b1, 9, 0));
    note_events.push_back(make_event(MODE_SET, 1, 12'h150, 1'b1, 10, 0));
    note_events.push_back(make_event(MODE_SET, 2, 12'h150, 1'b1, 6, 40));
    note_events.push_back(make_event(MODE_SET, 3, 12'h150, 1'b1, 15, 0));
    note_events.push_back(make_event(MODE_SET, 0, 12'h150, 1'b1, 0, 0));
    note_events.push_back(make_event(MODE_STOP, 1, 32767, 1'b1, 9, 255));
    wait_idle();

    for (int phase = 0; phase < 4; phase++) begin
      write_variant(phase[0] ? VARIANT_ADL : VARIANT_INS);
      // One phase runs with both sides always ready.
      steady = (phase == 2);
      queue_random(20);
      wait_idle();
    end
    steady = 1'b0;

    while (expected_writes.size() != 0) begin
      report_error($sformatf("missing write addr=%02h data=%02h",
                             expected_writes[0].reg_addr, expected_writes[0].reg_data));
      void'(expected_writes.pop_front());
    end
    $display("Sent %0d note events (%0d rhythm) under both driver variants,",
             events_sent, rhythm_events);
    $display("and checked %0d register writes.", writes_checked);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
